/* src/cbtm_pkg.sv */
// Shared types, constants and codes of the contact bounce timing meter.
package cbtm_pkg;

	localparam int TIME_BITS  = 20;
	localparam int COUNT_BITS = 16;
	localparam int REG_BITS   = 20;
	localparam int IDX_BITS   = 2;
	localparam int CMP_W      = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;

	localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [REG_BITS-1:0] SETTLE_RESET  = REG_BITS'(5000);
	localparam logic [REG_BITS-1:0] TIMEOUT_RESET = REG_BITS'(100000);

	typedef enum logic [IDX_BITS-1:0] {
		REG_SETTLE_TICKS  = 2'd0,
		REG_TIMEOUT_TICKS = 2'd1,
		REG_CLOSED_LEVEL  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t opcode;
		logic    target_on;
		logic    contact_level;
	} item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]  first_edge_time;
		logic [TIME_BITS-1:0]  settle_time;
		logic [COUNT_BITS-1:0] edge_count;
		logic                  success;
	} result_t;

	typedef struct packed {
		logic [REG_BITS-1:0] settle_ticks;
		logic [REG_BITS-1:0] timeout_ticks;
		logic                closed_level;
	} cfg_t;

endpackage

/* src/cbtm_cmd_if.sv */
// Command channel: valid/ready handshake carrying one input item.
interface cbtm_cmd_if;
	logic              valid;
	logic              ready;
	cbtm_pkg::opcode_t opcode;
	logic              target_on;
	logic              contact_level;

	modport source (output valid, output opcode, output target_on, output contact_level,
		input ready);
	modport sink (input valid, input opcode, input target_on, input contact_level,
		output ready);
endinterface

/* src/cbtm_res_if.sv */
// Result channel: valid/ready handshake carrying one measurement result.
interface cbtm_res_if;
	logic                                  valid;
	logic                                  ready;
	logic [cbtm_pkg::TIME_BITS-1:0]        first_edge_time;
	logic [cbtm_pkg::TIME_BITS-1:0]        settle_time;
	logic [cbtm_pkg::COUNT_BITS-1:0]       edge_count;
	logic                                  success;

	modport source (output valid, output first_edge_time, output settle_time,
		output edge_count, output success, input ready);
	modport sink (input valid, input first_edge_time, input settle_time,
		input edge_count, input success, output ready);
endinterface

/* src/cbtm_cfg_if.sv */
// Configuration write channel: valid/ready handshake carrying register index and data.
interface cbtm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cbtm_pkg::IDX_BITS-1:0]     index;
	logic [cbtm_pkg::REG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/contact_bounce_timing_meter.sv */
// Contact bounce timing meter: top level joining input, measurement and result stages.
// A result is offered from the result register once its ending tick has left the input register.
// Throughput: one command transaction per cycle, sustained, while results are taken as offered.
// The input register, the single-pass state update and the result register set this rate.
// Reset (arst_n low, asynchronous) empties both stages, stops any measurement, sets the previous
// contact level to open and loads the settle and timeout registers with 5000 and 100000 ticks.
module contact_bounce_timing_meter (
	input  logic      clk,
	input  logic      arst_n,
	cbtm_cmd_if.sink  cmd,
	cbtm_res_if.source res,
	cbtm_cfg_if.sink  cfg
);
	import cbtm_pkg::*;

	// Configuration writes are always taken; the register file decodes the index.
	cfg_t    cfg_regs;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    step;
	logic    res_valid;
	result_t res_d;

	assign cfg.ready = 1'b1;

	cbtm_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// The held command moves into the measurement stage whenever the result register can
	// take whatever that command produces, so a waiting result holds the input register.
	assign step = valid_s1 && out_free;

	cbtm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Each step updates the measurement state in one pass: edge detection against the
	// previous sample, edge times and count, then the settle check ahead of the timeout check.
	cbtm_meas u_meas (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg_regs),
		.res_valid (res_valid),
		.res       (res_d)
	);

	cbtm_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res_d  (res_d),
		.free   (out_free),
		.res    (res)
	);

endmodule

/* src/cbtm_cfg_regs.sv */
// Configuration register file of the contact bounce timing meter.
module cbtm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [cbtm_pkg::IDX_BITS-1:0] wr_index,
	input  logic [cbtm_pkg::REG_BITS-1:0] wr_data,
	output cbtm_pkg::cfg_t cfg
);
	import cbtm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks  <= SETTLE_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
			cfg_q.closed_level  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_SETTLE_TICKS:  cfg_q.settle_ticks  <= wr_data;
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= wr_data;
				REG_CLOSED_LEVEL:  cfg_q.closed_level  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/cbtm_in_reg.sv */
// Input register stage that holds one accepted command for the measurement stage.
module cbtm_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	cbtm_cmd_if.sink      cmd,
	input  logic          advance,
	output logic          valid_s1,
	output cbtm_pkg::item_t item_s1
);
	import cbtm_pkg::*;

	logic  vld_s1;
	item_t itm_s1;

	assign cmd.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			itm_s1.opcode        <= cmd.opcode;
			itm_s1.target_on     <= cmd.target_on;
			itm_s1.contact_level <= cmd.contact_level;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = itm_s1;

endmodule

/* src/cbtm_meas.sv */
// Measurement state and the single-pass update that edge-detects, times and finishes.
module cbtm_meas (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  cbtm_pkg::item_t item,
	input  cbtm_pkg::cfg_t  cfg,
	output logic            res_valid,
	output cbtm_pkg::result_t res
);
	import cbtm_pkg::*;

	logic                  busy_q;
	logic                  expected_q;
	logic                  prev_level_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic [TIME_BITS-1:0]  first_edge_q;
	logic [TIME_BITS-1:0]  last_edge_q;
	logic [COUNT_BITS-1:0] edges_q;

	logic                  is_start;
	logic                  edge_seen;
	logic [TIME_BITS-1:0]  elapsed_n;
	logic [TIME_BITS-1:0]  first_n;
	logic [TIME_BITS-1:0]  last_n;
	logic [COUNT_BITS-1:0] edges_n;
	logic [TIME_BITS-1:0]  quiet;
	logic                  settled;
	logic                  timed_out;

	always_comb begin
		is_start  = (item.opcode == OP_START);
		elapsed_n = (elapsed_q != TIME_MAX) ? elapsed_q + TIME_BITS'(1) : elapsed_q;
		edge_seen = (item.contact_level != prev_level_q);
		first_n   = (edge_seen && edges_q == '0) ? elapsed_n : first_edge_q;
		last_n    = edge_seen ? elapsed_n : last_edge_q;
		edges_n   = (edge_seen && edges_q != COUNT_MAX) ? edges_q + COUNT_BITS'(1) : edges_q;
		// Elapsed never falls behind the last edge, so this difference cannot wrap.
		quiet     = elapsed_n - last_n;
		settled   = (edges_n != '0) && (CMP_W'(quiet) >= CMP_W'(cfg.settle_ticks));
		timed_out = (CMP_W'(elapsed_n) >= CMP_W'(cfg.timeout_ticks)) || (elapsed_n == TIME_MAX);

		res_valid           = step && !is_start && busy_q && (settled || timed_out);
		res.first_edge_time = first_n;
		res.settle_time     = last_n;
		res.edge_count      = edges_n;
		res.success         = settled && (item.contact_level == expected_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			expected_q   <= 1'b0;
			prev_level_q <= 1'b1;
			elapsed_q    <= '0;
			first_edge_q <= '0;
			last_edge_q  <= '0;
			edges_q      <= '0;
		end else if (step) begin
			prev_level_q <= item.contact_level;
			if (is_start) begin
				busy_q       <= 1'b1;
				expected_q   <= item.target_on ? cfg.closed_level : !cfg.closed_level;
				elapsed_q    <= '0;
				first_edge_q <= '0;
				last_edge_q  <= '0;
				edges_q      <= '0;
			end else if (busy_q) begin
				busy_q       <= !(settled || timed_out);
				elapsed_q    <= elapsed_n;
				first_edge_q <= first_n;
				last_edge_q  <= last_n;
				edges_q      <= edges_n;
			end
		end
	end

	a_no_edge_no_times: assert property (@(posedge clk) disable iff (!arst_n)
		(edges_q == '0) |-> (first_edge_q == '0 && last_edge_q == '0))
		else $error("edge times set without any edge counted");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(first_edge_q <= last_edge_q) && (last_edge_q <= elapsed_q))
		else $error("edge times out of order");

	a_result_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !busy_q)
		else $error("measurement still running after its result");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && is_start) |=> (busy_q && elapsed_q == '0 && edges_q == '0))
		else $error("start did not open a clean measurement");

endmodule

/* src/cbtm_out_reg.sv */
// Result register that holds a finished measurement until the result channel takes it.
module cbtm_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cbtm_pkg::result_t res_d,
	output logic              free,
	cbtm_res_if.source        res
);
	import cbtm_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_d;
		end
	end

	assign res.valid           = valid_q;
	assign res.first_edge_time = data_q.first_edge_time;
	assign res.settle_time     = data_q.settle_time;
	assign res.edge_count      = data_q.edge_count;
	assign res.success         = data_q.success;

endmodule

/* tb/sv/contact_bounce_timing_meter_test.sv */
`timescale 1ns / 100ps
// Self-checking random and directed test of the contact bounce timing meter.
module contact_bounce_timing_meter_test;
	import cbtm_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 12;
	// Watchdog limit for the whole run.
	localparam int CYCLE_LIMIT  = 200_000;
	localparam int RANDOM_ITEMS = 1300;
	// Idle time after the last report, so that the pipeline can empty.
	localparam int DRAIN_CYCLES = 6;

	logic clk;
	logic arst_n;

	cbtm_cmd_if cmd ();
	cbtm_res_if res ();
	cbtm_cfg_if cfg ();

	contact_bounce_timing_meter dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.res   (res),
		.cfg   (cfg)
	);

	// Register copies held by the prediction side.
	logic [REG_BITS-1:0]   settle_reg;
	logic [REG_BITS-1:0]   timeout_reg;
	logic                  closed_reg;

	// Measurement state as the meter should hold it.
	logic                  measuring;
	logic                  want_level;
	logic                  prior_level;
	logic [TIME_BITS-1:0]  ticks_since_start;
	logic [TIME_BITS-1:0]  first_edge_at;
	logic [TIME_BITS-1:0]  last_edge_at;
	logic [COUNT_BITS-1:0] edge_total;

	// Samples and commands waiting to be sent, and the reports the meter owes us.
	item_t   sample_queue[$];
	result_t measurement_reports[$];

	// When set, neither side inserts idle cycles.
	bit steady;

	int unsigned active_items;
	int unsigned register_writes;
	int unsigned reports_checked;
	int unsigned timeouts_seen;
	int unsigned mismatches;
	int unsigned cycle_count = 0;
	int unsigned send_gap;
	int unsigned take_gap;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost report ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped by the watchdog after %0d cycles.", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	// Follow a register write into the predicted configuration.
	task automatic apply_register(input reg_idx_t idx, input logic [REG_BITS-1:0] val);
		case (idx)
			REG_SETTLE_TICKS:  settle_reg = val;
			REG_TIMEOUT_TICKS: timeout_reg = val;
			REG_CLOSED_LEVEL:  closed_reg = val[0];
			default: ;
		endcase
	endtask

	// Advance the predicted meter by one accepted command transaction and queue the
	// report that it ends with, if any.
	task automatic meter_step(input item_t it);
		result_t rpt;
		if (it.opcode == OP_START) begin
			// A start drops whatever measurement was running, without a report.
			measuring = 1'b1;
			want_level = it.target_on ? closed_reg : ~closed_reg;
			prior_level = it.contact_level;
			ticks_since_start = '0;
			first_edge_at = '0;
			last_edge_at = '0;
			edge_total = '0;
			active_items++;
			return;
		end
		if (!measuring) begin
			// Idle ticks only move the reference level.
			prior_level = it.contact_level;
			return;
		end
		active_items++;
		if (ticks_since_start != TIME_MAX)
			ticks_since_start++;
		if (it.contact_level != prior_level) begin
			if (edge_total == '0)
				first_edge_at = ticks_since_start;
			last_edge_at = ticks_since_start;
			// The count sticks at all ones while the edge times keep moving.
			if (edge_total != COUNT_MAX)
				edge_total++;
		end
		prior_level = it.contact_level;
		rpt.first_edge_time = first_edge_at;
		rpt.settle_time = last_edge_at;
		rpt.edge_count = edge_total;
		// Settling is judged first, so it wins when the timeout falls on the same tick.
		if (edge_total != '0 &&
			CMP_W'(ticks_since_start - last_edge_at) >= CMP_W'(settle_reg)) begin
			rpt.success = (it.contact_level == want_level);
			measurement_reports.push_back(rpt);
			measuring = 1'b0;
		end else if (CMP_W'(ticks_since_start) >= CMP_W'(timeout_reg) ||
			ticks_since_start == TIME_MAX) begin
			rpt.success = 1'b0;
			measurement_reports.push_back(rpt);
			measuring = 1'b0;
			timeouts_seen++;
		end
	endtask

	task automatic check_field(input string field, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// Command driver. Each transaction is predicted at the edge that accepts it,
	// then the next queued item goes out after a random number of idle cycles, none when steady.
	always @(posedge clk or negedge arst_n) begin
		item_t nxt;
		item_t taken;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.opcode <= OP_TICK;
			cmd.target_on <= 1'b0;
			cmd.contact_level <= 1'b0;
			send_gap <= 0;
			// The predicted meter comes out of reset with the block.
			measuring = 1'b0;
			want_level = 1'b0;
			prior_level = 1'b1;
			ticks_since_start = '0;
			first_edge_at = '0;
			last_edge_at = '0;
			edge_total = '0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				taken.opcode = cmd.opcode;
				taken.target_on = cmd.target_on;
				taken.contact_level = cmd.contact_level;
				meter_step(taken);
			end
			if (!cmd.valid || cmd.ready) begin
				if (send_gap != 0) begin
					cmd.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (sample_queue.size() != 0) begin
					nxt = sample_queue.pop_front();
					cmd.valid <= 1'b1;
					cmd.opcode <= nxt.opcode;
					cmd.target_on <= nxt.target_on;
					cmd.contact_level <= nxt.contact_level;
					send_gap <= steady ? 0 : $urandom_range(0, 3);
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// Report monitor. Every accepted report is matched against the oldest prediction;
	// after each one the sink stalls for a random number of cycles, or not at all when steady.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		int unsigned wait_next;
		if (!arst_n) begin
			res.ready <= 1'b0;
			take_gap <= 0;
		end else begin
			wait_next = take_gap;
			if (res.valid && res.ready) begin
				reports_checked++;
				if (measurement_reports.size() == 0) begin
					mismatches++;
					$display("%0t: report expected none, got settle %0d edges %0d",
						$time, res.settle_time, res.edge_count);
				end else begin
					want = measurement_reports.pop_front();
					check_field("first_edge_time", want.first_edge_time, res.first_edge_time);
					check_field("settle_time", want.settle_time, res.settle_time);
					check_field("edge_count", want.edge_count, res.edge_count);
					check_field("success", want.success, res.success);
				end
				wait_next = steady ? 0 : $urandom_range(0, 3);
			end
			if (wait_next != 0) begin
				res.ready <= 1'b0;
				take_gap <= wait_next - 1;
			end else begin
				res.ready <= 1'b1;
				take_gap <= 0;
			end
		end
	end

	task automatic queue_item(input opcode_t op, input logic tgt, input logic lvl);
		item_t it;
		it.opcode = op;
		it.target_on = tgt;
		it.contact_level = lvl;
		sample_queue.push_back(it);
	endtask

	task automatic queue_ticks(input logic lvl, input int unsigned count);
		repeat (count)
			queue_item(OP_TICK, coin(), lvl);
	endtask

	// Hold off the sender until every queued item has gone out and every predicted
	// report has come back, then give the pipeline time to empty.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || cmd.valid || measurement_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [REG_BITS-1:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		apply_register(idx, val);
		cfg.valid <= 1'b0;
		register_writes++;
	endtask

	task automatic configure(input logic [REG_BITS-1:0] settle,
		input logic [REG_BITS-1:0] timeout, input logic closed);
		write_register(REG_SETTLE_TICKS, settle);
		write_register(REG_TIMEOUT_TICKS, timeout);
		write_register(REG_CLOSED_LEVEL, REG_BITS'(closed));
		@(negedge clk);
	endtask

	// One well-formed measurement: a start, a burst of bouncing, then a quiet
	// stretch long enough to settle or time out. Now and then the quiet stretch is
	// cut short so that the next start drops the measurement.
	task automatic queue_measurement();
		logic lvl;
		logic goal;
		logic goal_lvl;
		int unsigned hold;
		lvl = coin();
		goal = coin();
		goal_lvl = goal ? closed_reg : ~closed_reg;
		queue_item(OP_START, goal, lvl);
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 9) < 6)
				lvl = ~lvl;
			queue_item(OP_TICK, coin(), lvl);
		end
		// Mostly land at the expected level, sometimes at the wrong one.
		lvl = ($urandom_range(0, 3) != 0) ? goal_lvl : ~goal_lvl;
		hold = 32'((settle_reg < timeout_reg) ? settle_reg : timeout_reg);
		if (hold > 300)
			hold = 300;
		hold += $urandom_range(1, 3);
		if ($urandom_range(0, 9) == 0)
			hold = $urandom_range(0, 2);
		queue_ticks(lvl, hold);
	endtask

	// Stray transactions with random fields: idle ticks, lone starts and restarts.
	task automatic queue_noise();
		repeat ($urandom_range(1, 4))
			queue_item(opcode_t'($urandom_range(0, 1)), coin(), coin());
	endtask

	initial begin
		int unsigned base_items;
		logic [REG_BITS-1:0] settle;
		logic [REG_BITS-1:0] timeout;

		// Reset and the configuration channel start at known values; the driver and
		// the monitor clear their own outputs while reset is held.
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_SETTLE_TICKS;
		cfg.data = '0;
		steady = 1'b0;

		settle_reg = SETTLE_RESET;
		timeout_reg = TIMEOUT_RESET;
		closed_reg = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values of the registers: two level changes and a short quiet stretch. Closed is
		// low, so an open target wants a high level. The settle window is then cut down
		// while the measurement runs, and the next tick ends it.
		queue_item(OP_TICK, 1'b0, 1'b0);
		queue_item(OP_START, 1'b0, 1'b1);
		queue_item(OP_TICK, 1'b0, 1'b0);
		queue_item(OP_TICK, 1'b0, 1'b1);
		queue_ticks(1'b1, 3);
		wait_idle();
		write_register(REG_SETTLE_TICKS, REG_BITS'(3));
		queue_ticks(1'b1, 1);
		wait_idle();

		// Short windows, closed high.
		configure(REG_BITS'(2), REG_BITS'(10), 1'b1);
		// Settles at the wrong level.
		queue_item(OP_START, 1'b1, 1'b0);
		queue_item(OP_TICK, 1'b0, 1'b1);
		queue_ticks(1'b0, 3);
		// Settles at the expected level after a single edge.
		queue_item(OP_START, 1'b1, 1'b0);
		queue_ticks(1'b1, 3);
		// A restart while busy drops the first measurement; the second never sees
		// an edge and runs into the timeout.
		queue_item(OP_START, 1'b0, 1'b1);
		queue_item(OP_TICK, 1'b1, 1'b0);
		queue_item(OP_START, 1'b0, 1'b0);
		queue_ticks(1'b0, 10);
		// Ticks while idle produce nothing.
		queue_item(OP_TICK, 1'b1, 1'b1);
		queue_item(OP_TICK, 1'b0, 1'b0);
		wait_idle();

		// Zero windows: the first edge settles at once, no edge fails on the first tick.
		configure('0, '0, 1'b0);
		queue_item(OP_START, 1'b1, 1'b1);
		queue_item(OP_TICK, 1'b0, 1'b0);
		queue_item(OP_START, 1'b0, 1'b0);
		queue_item(OP_TICK, 1'b1, 1'b0);
		wait_idle();

		// Largest settle window: only the timeout can end the measurement.
		configure('1, REG_BITS'(3), 1'b1);
		queue_item(OP_START, 1'b1, 1'b0);
		queue_ticks(1'b1, 3);
		wait_idle();

		// Largest timeout: settling ends it.
		configure(REG_BITS'(1), '1, 1'b0);
		queue_item(OP_START, 1'b0, 1'b0);
		queue_ticks(1'b1, 2);
		wait_idle();

		// Settle and timeout on the same tick, with a late edge; settling wins.
		configure(REG_BITS'(2), REG_BITS'(4), 1'b0);
		queue_item(OP_START, 1'b1, 1'b1);
		queue_item(OP_TICK, 1'b0, 1'b1);
		queue_ticks(1'b0, 3);
		wait_idle();

		// Random phases, each with a fresh register setting and idling style, each
		// ending with the sender held off until all reports are in.
		base_items = active_items;
		while (active_items - base_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					settle = '1;
					timeout = REG_BITS'($urandom_range(0, 60));
				end
				1: begin
					settle = REG_BITS'($urandom_range(0, 8));
					timeout = coin() ? '1 : REG_BITS'($urandom_range(1000, 1048575));
				end
				2: begin
					settle = '0;
					timeout = REG_BITS'($urandom_range(0, 40));
				end
				3: begin
					settle = REG_BITS'($urandom_range(1, 12));
					timeout = '0;
				end
				default: begin
					settle = REG_BITS'($urandom_range(1, 12));
					timeout = REG_BITS'($urandom_range(0, 80));
				end
			endcase
			configure(settle, timeout, coin());
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) == 0)
					queue_noise();
				queue_measurement();
			end
			if ($urandom_range(0, 3) == 0)
				queue_noise();
			wait_idle();
		end

		if (measurement_reports.size() != 0) begin
			$display("%0t: outstanding reports expected 0, got %0d", $time,
				measurement_reports.size());
		end

		$display("Sent %0d measuring transactions with %0d register writes across settings.",
			active_items, register_writes);
		$display("Compared %0d reports (%0d by timeout), %0d mismatches.",
			reports_checked, timeouts_seen, mismatches);
		if (mismatches == 0 && measurement_reports.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/cbtm_pkg.sv
src/cbtm_cmd_if.sv
src/cbtm_res_if.sv
src/cbtm_cfg_if.sv
src/cbtm_cfg_regs.sv
src/cbtm_in_reg.sv
src/cbtm_meas.sv
src/cbtm_out_reg.sv
src/contact_bounce_timing_meter.sv
tb/sv/contact_bounce_timing_meter_test.sv
